FILE: rtl/shs_pkg.sv
// Shared types and constants of the searchable handle stack.
package shs_pkg;

  localparam int SHS_DEPTH      = 256;
  localparam int SHS_VALUE_BITS = 32;
  localparam int SHS_POS_BITS   = 9;
  localparam int SHS_POSO_BITS  = 8;
  localparam int SHS_DATA_BITS  = 32;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_FIND   = 2'd2,
    OP_LOOKUP = 2'd3
  } shs_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } shs_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HOLD,
    S_READ,
    S_SEARCH
  } shs_state_e;

  typedef struct packed {
    shs_op_e                   op;
    logic [SHS_DATA_BITS-1:0]  value;
    logic [SHS_POS_BITS-1:0]   position;
  } shs_in_t;

  typedef struct packed {
    logic [SHS_DATA_BITS-1:0]  value_out;
    logic [SHS_POSO_BITS-1:0]  position_out;
    logic                      found;
    shs_status_e               status;
  } shs_out_t;

endpackage

FILE: rtl/searchable_handle_stack_unit.sv
// Searchable handle stack: bounded LIFO of handles with a sequential search.
//
//  channel | signals                         | direction | contents
//  --------+---------------------------------+-----------+----------------------------
//  in      | in_valid_i, in_ready_o, in_data_i   | to block  | op, value, position
//  out     | out_valid_o, out_ready_i, out_data_o | from block | value_out, position_out,
//          |                                 |           | found, status
//
// Push, pop, lookup and a find on an empty stack first accept and decode the item, then
// read the entry memory (or hold an immediate status) into the output register.
// Find reports a match's distance from the top, or no match once the bottom entry misses:
// one entry per cycle goes through the single read port and comparator, top first.
// Reset clears the fill count and control state; entries are never cleared or read unwritten.
// A stalled output register holds its item; the sequencer waits only to load the next one.
module searchable_handle_stack_unit
  import shs_pkg::*;
#(
  parameter int DEPTH      = SHS_DEPTH,
  parameter int VALUE_BITS = SHS_VALUE_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  shs_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output shs_out_t out_data_o
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > SHS_POS_BITS) ? CW : SHS_POS_BITS;

  // Entry memory: one write and one registered read per cycle.
  logic [VALUE_BITS-1:0] mem_q [DEPTH];
  logic [VALUE_BITS-1:0] rdata_q;

  shs_state_e            state_q, state_d;
  logic [CW-1:0]         fill_q, fill_d;
  logic [AW-1:0]         addr_q, addr_d;
  logic [AW-1:0]         dist_q, dist_d;
  logic [VALUE_BITS-1:0] key_q, key_d;
  shs_out_t              hold_q, hold_d;
  logic                  out_valid_q;
  shs_out_t              out_q;

  logic                  wr_en, rd_en;
  logic [AW-1:0]         rd_addr;
  logic [VALUE_BITS-1:0] in_val;
  logic                  res_valid;
  shs_out_t              res;
  logic                  out_free;
  logic                  is_full, is_empty;
  logic [CMPW-1:0]       fill_ext, pos_ext;
  logic                  pos_lt, pos_gt;
  logic                  hit, at_bottom;

  // Decode helpers
  assign in_val    = VALUE_BITS'(in_data_i.value);
  assign is_full   = (fill_q == CW'(DEPTH));
  assign is_empty  = (fill_q == '0);
  assign fill_ext  = CMPW'(fill_q);
  assign pos_ext   = CMPW'(in_data_i.position);
  assign pos_lt    = (pos_ext < fill_ext);
  assign pos_gt    = (pos_ext > fill_ext);
  assign out_free  = !out_valid_q || out_ready_i;
  // The shared comparator: current entry against the search key
  assign hit       = (rdata_q == key_q);
  assign at_bottom = (addr_q == '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.op)
            OP_PUSH:   state_d = S_HOLD;
            OP_POP:    state_d = is_empty ? S_HOLD : S_READ;
            OP_FIND:   state_d = is_empty ? S_HOLD : S_SEARCH;
            OP_LOOKUP: state_d = pos_lt ? S_READ : S_HOLD;
            default:   state_d = S_HOLD;
          endcase
        end
      end
      S_HOLD, S_READ: begin
        if (out_free) state_d = S_IDLE;
      end
      S_SEARCH: begin
        if ((hit || at_bottom) && out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath control and result selection
  always_comb begin
    in_ready_o = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = addr_q;
    fill_d     = fill_q;
    addr_d     = addr_q;
    dist_d     = dist_q;
    key_d      = key_q;
    hold_d     = hold_q;
    res_valid  = 1'b0;
    res        = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          hold_d = '0;
          case (in_data_i.op)
            OP_PUSH: begin
              if (is_full) begin
                hold_d.status = ST_FULL;
              end else begin
                wr_en  = 1'b1;
                fill_d = fill_q + 1'b1;
              end
            end
            OP_POP: begin
              if (is_empty) begin
                hold_d.status = ST_EMPTY;
              end else begin
                fill_d  = fill_q - 1'b1;
                rd_en   = 1'b1;
                rd_addr = AW'(fill_q - 1'b1);
              end
            end
            OP_FIND: begin
              // Start at the top and walk down
              key_d   = in_val;
              rd_en   = !is_empty;
              rd_addr = AW'(fill_q - 1'b1);
              addr_d  = AW'(fill_q - 1'b1);
              dist_d  = '0;
            end
            OP_LOOKUP: begin
              if (pos_lt) begin
                rd_en   = 1'b1;
                rd_addr = AW'(fill_ext - pos_ext - 1'b1);
              end else if (pos_gt) begin
                hold_d.status = ST_RANGE;
              end
            end
            default: begin
              hold_d = '0;
            end
          endcase
        end
      end
      S_HOLD: begin
        res_valid = 1'b1;
        res       = hold_q;
      end
      S_READ: begin
        res_valid     = 1'b1;
        res.value_out = SHS_DATA_BITS'(rdata_q);
      end
      S_SEARCH: begin
        if (hit) begin
          res_valid        = 1'b1;
          res.found        = 1'b1;
          res.position_out = SHS_POSO_BITS'(dist_q);
        end else if (at_bottom) begin
          res_valid = 1'b1;
        end else begin
          // Advance one entry toward the bottom
          rd_en   = 1'b1;
          rd_addr = addr_q - 1'b1;
          addr_d  = addr_q - 1'b1;
          dist_d  = dist_q + 1'b1;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Entry memory
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[fill_q[AW-1:0]] <= in_val;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      if (res_valid && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    dist_q <= dist_d;
    key_q  <= key_d;
    hold_q <= hold_d;
    if (res_valid && out_free) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_push_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.op == OP_PUSH && !is_full)
      |=> fill_q == CW'($past(fill_q) + 1'b1))
    else $error("push did not grow the stack");

  a_pop_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.op == OP_POP && !is_empty)
      |=> fill_q == CW'($past(fill_q) - 1'b1))
    else $error("pop did not shrink the stack");

  a_search_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> CW'(addr_q) < fill_q)
    else $error("search walked outside the filled entries");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.found) |-> out_data_o.status == ST_OK)
    else $error("match reported with error status");

endmodule
